// ----- hdl/ppfs_pkg.sv -----
// Package for the per-pixel frame statistics block: operation codes, configuration
// indices, command codes, pass phases, controller states and fixed field widths. No dependencies.
package ppfs_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned MEAN_W    = 24;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned OPC_W     = 3;
  localparam int unsigned FCNT_W    = 11;
  localparam int unsigned PPF_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned RES_W     = 50;
  localparam int unsigned OUT_DATA_W = 56;
  // divider dividend: accumulator with fraction bits appended
  localparam int unsigned DIVN_W    = ACC_W + FRAC_W;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned SQ_STEPS  = DIVN_W / 2;
  localparam int unsigned ROOT_W    = DIVN_W / 2;
  localparam int unsigned SREM_W    = ROOT_W + 3;

  localparam logic [CFG_IDX_W-1:0] CFG_OPERATION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_CNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXELS     = 2'd2;

  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [OPC_W-1:0] {
    OP_SUM    = 3'd0,
    OP_MEAN   = 3'd1,
    OP_MIN    = 3'd2,
    OP_MAX    = 3'd3,
    OP_VAR    = 3'd4,
    OP_SVAR   = 3'd5,
    OP_STDEV  = 3'd6,
    OP_SSTDEV = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    PASS_FIRST  = 2'd0,
    PASS_SECOND = 2'd1,
    PASS_DONE   = 2'd2
  } pass_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FEED_RD,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_RD_RD,
    ST_OUT
  } state_e;

endpackage

// ----- hdl/per_pixel_frame_statistics_top.sv -----
// Per-pixel frame statistics: controller, per-pixel stores, serial divider
// and serial square root in one module. Depends on ppfs_pkg.
//
// Samples stream in raster order and each pixel keeps a 48-bit accumulator
// and a 24-bit mean in single-port synchronous memories with a registered read.
// Every word is handled to completion before the next is taken, so the
// rate follows the memory read-modify-write and the shared bit-serial
// units: a second-pass feed also passes through the difference, multiply
// and accumulate steps, and on frame 0 the divider first forms the pixel
// mean. A read of sum, min or max returns the stored word; mean and
// variance add the divider, and deviation adds the square root after it.
// A result waits in the output register while the next word is taken. The
// stores are not cleared; a run must complete before reads return data. A
// configuration write restarts the run at pixel 0, frame 0, first pass.
module per_pixel_frame_statistics_top #(
  parameter int unsigned MAX_PIXELS = 65536,
  parameter int unsigned MAX_FRAMES = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // stream in
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: sample_value[15:0], read_index[31:16]
  input  logic [ppfs_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // tuser: command
  input  logic                              s_axis_tuser_i,
  // stream out
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: result_value[47:0], not_ready[48], divide_error[49], zero pad
  output logic [ppfs_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [ppfs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ppfs_pkg::CFG_W-1:0]        cfg_data_i
);
  import ppfs_pkg::*;

  localparam int unsigned PW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned FW = $clog2(MAX_FRAMES + 1);

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // control state
  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [FCNT_W-1:0]  fcnt_q, fcnt_d;
  logic [PPF_W-1:0]   ppf_q, ppf_d;
  pass_e              phase_q, phase_d;
  logic [PW-1:0]      pix_q, pix_d;
  logic [FW-1:0]      frame_q, frame_d;
  logic               out_valid_q, out_valid_d;

  // datapath registers
  logic               is_feed_q, is_feed_d;
  logic [SAMPLE_W-1:0] x_q, x_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [MEAN_W-1:0]  m_q, m_d;
  logic [MEAN_W-1:0]  dv_q, dv_d;
  logic [ACC_W-1:0]   sq_q, sq_d;
  logic [DIVN_W-1:0]  num_q, num_d;
  logic [FW-1:0]      rem_q, rem_d;
  logic [FW-1:0]      den_q, den_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SREM_W-1:0]  srem_q, srem_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic [ACC_W-1:0]   res_q, res_d;
  logic               nr_q, nr_d;
  logic               de_q, de_d;
  logic [RES_W-1:0]   out_data_q, out_data_d;

  // memories
  logic [ACC_W-1:0]   acc_mem [MAX_PIXELS];
  logic [MEAN_W-1:0]  mean_mem [MAX_PIXELS];
  logic [ACC_W-1:0]   acc_rd_q;
  logic [MEAN_W-1:0]  mean_rd_q;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               acc_we;
  logic [ACC_W-1:0]   acc_wdata;
  logic               mean_we;
  logic [MEAN_W-1:0]  mean_wdata;

  // effective frame and pixel counts
  logic [FW-1:0]      nf;
  logic [PW-1:0]      np;
  logic [31:0]        fcnt_ext, ppf_ext;

  always_comb begin
    fcnt_ext = 32'(fcnt_q);
    ppf_ext  = 32'(ppf_q);
    if (fcnt_ext == 32'd0) begin
      nf = FW'(1);
    end else if (fcnt_ext > 32'(MAX_FRAMES)) begin
      nf = FW'(MAX_FRAMES);
    end else begin
      nf = FW'(fcnt_ext);
    end
    if (ppf_ext == 32'd0) begin
      np = PW'(1);
    end else if (ppf_ext > 32'(MAX_PIXELS)) begin
      np = PW'(MAX_PIXELS);
    end else begin
      np = PW'(ppf_ext);
    end
  end

  // position of the word being taken
  pass_e              cur_phase;
  logic [FW-1:0]      cur_frame;
  logic [PW-1:0]      cur_pix;

  always_comb begin
    if (phase_q == PASS_DONE) begin
      cur_phase = PASS_FIRST;
      cur_frame = '0;
      cur_pix   = '0;
    end else begin
      cur_phase = phase_q;
      cur_frame = frame_q;
      cur_pix   = (pix_q >= np) ? '0 : pix_q;
    end
  end

  // position after the current feed
  logic [PW:0]        pix_inc;
  logic [FW:0]        frame_inc;
  logic [PW-1:0]      adv_pix;
  logic [FW-1:0]      adv_frame;
  pass_e              adv_phase;

  always_comb begin
    pix_inc   = {1'b0, pix_q} + 1'b1;
    frame_inc = {1'b0, frame_q} + 1'b1;
    adv_pix   = pix_inc[PW-1:0];
    adv_frame = frame_q;
    adv_phase = phase_q;
    if (pix_inc >= {1'b0, np}) begin
      adv_pix   = '0;
      adv_frame = frame_inc[FW-1:0];
      if (frame_inc >= {1'b0, nf}) begin
        adv_frame = '0;
        if (phase_q == PASS_FIRST && op_q[2]) begin
          adv_phase = PASS_SECOND;
        end else begin
          adv_phase = PASS_DONE;
        end
      end
    end
  end

  // first-pass and second-pass update of one accumulator
  logic [ACC_W:0]     sum_first, sum_second;
  logic [ACC_W-1:0]   x_ext, first_val, second_val;

  always_comb begin
    x_ext     = ACC_W'(x_q);
    sum_first = {1'b0, acc_rd_q} + {1'b0, x_ext};
    if (frame_q == '0) begin
      first_val = x_ext;
    end else if (op_q == OP_MIN) begin
      first_val = (x_ext < acc_rd_q) ? x_ext : acc_rd_q;
    end else if (op_q == OP_MAX) begin
      first_val = (x_ext > acc_rd_q) ? x_ext : acc_rd_q;
    end else begin
      first_val = sum_first[ACC_W] ? ACC_MAX : sum_first[ACC_W-1:0];
    end
    sum_second = {1'b0, acc_q} + {1'b0, sq_q};
    if (frame_q == '0) begin
      second_val = sq_q;
    end else begin
      second_val = sum_second[ACC_W] ? ACC_MAX : sum_second[ACC_W-1:0];
    end
  end

  // one restoring divider step
  logic [FW:0]        div_r;
  logic               div_bit;
  logic [FW-1:0]      div_rem;
  logic [DIVN_W-1:0]  quot_next;

  always_comb begin
    div_r   = {rem_q, num_q[DIVN_W-1]};
    div_bit = (div_r >= {1'b0, den_q});
    div_rem = div_bit ? FW'(div_r - {1'b0, den_q}) : div_r[FW-1:0];
    quot_next = {num_q[DIVN_W-2:0], div_bit};
  end

  // one square root step, two radicand bits at a time
  logic [SREM_W-1:0]  sq_rem_sh, sq_trial;
  logic               sq_bit;
  logic [ROOT_W-1:0]  root_next;

  always_comb begin
    sq_rem_sh = {srem_q[SREM_W-3:0], num_q[DIVN_W-1 -: 2]};
    sq_trial  = SREM_W'({root_q, 2'b01});
    sq_bit    = (sq_rem_sh >= sq_trial);
    root_next = {root_q[ROOT_W-2:0], sq_bit};
  end

  logic [MEAN_W-1:0]  xs;
  logic [ACC_W-1:0]   prod;
  logic [FW-1:0]      var_den;

  assign xs      = {x_q, 8'b0};
  assign prod    = ACC_W'(dv_q) * ACC_W'(dv_q);
  assign var_den = (op_q == OP_SVAR || op_q == OP_SSTDEV) ? (nf - 1'b1) : nf;

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    fcnt_d      = fcnt_q;
    ppf_d       = ppf_q;
    phase_d     = phase_q;
    pix_d       = pix_q;
    frame_d     = frame_q;
    out_valid_d = out_valid_q;
    is_feed_d   = is_feed_q;
    x_d         = x_q;
    acc_d       = acc_q;
    m_d         = m_q;
    dv_d        = dv_q;
    sq_d        = sq_q;
    num_d       = num_q;
    rem_d       = rem_q;
    den_d       = den_q;
    cnt_d       = cnt_q;
    srem_d      = srem_q;
    root_d      = root_q;
    res_d       = res_q;
    nr_d        = nr_q;
    de_d        = de_q;
    out_data_d  = out_data_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    acc_we      = 1'b0;
    acc_wdata   = first_val;
    mean_we     = 1'b0;
    mean_wdata  = quot_next[MEAN_W-1:0];
    s_axis_tready_o = 1'b0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == CMD_FEED) begin
            is_feed_d = 1'b1;
            x_d       = s_axis_tdata_i[SAMPLE_W-1:0];
            phase_d   = cur_phase;
            frame_d   = cur_frame;
            pix_d     = cur_pix;
            rd_en     = 1'b1;
            rd_addr   = cur_pix[AW-1:0];
            state_d   = ST_FEED_RD;
          end else begin
            is_feed_d = 1'b0;
            res_d     = '0;
            nr_d      = 1'b0;
            de_d      = 1'b0;
            if (phase_q != PASS_DONE) begin
              nr_d    = 1'b1;
              state_d = ST_OUT;
            end else if (32'(s_axis_tdata_i[SAMPLE_W +: INDEX_W]) < 32'(np)) begin
              rd_en   = 1'b1;
              rd_addr = AW'(s_axis_tdata_i[SAMPLE_W +: INDEX_W]);
              state_d = ST_RD_RD;
            end else begin
              state_d = ST_OUT;
            end
          end
        end
      end
      ST_FEED_RD: begin
        acc_d = acc_rd_q;
        if (phase_q == PASS_FIRST) begin
          acc_we    = 1'b1;
          acc_wdata = first_val;
          pix_d     = adv_pix;
          frame_d   = adv_frame;
          phase_d   = adv_phase;
          state_d   = ST_IDLE;
        end else if (frame_q == '0) begin
          // mean of this pixel is formed on its first second-pass sample
          num_d   = {acc_rd_q, {FRAC_W{1'b0}}};
          rem_d   = '0;
          den_d   = nf;
          cnt_d   = '0;
          state_d = ST_DIV;
        end else begin
          m_d     = mean_rd_q;
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        dv_d    = (xs >= m_q) ? (xs - m_q) : (m_q - xs);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        sq_d    = prod >> FRAC_W;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_we    = 1'b1;
        acc_wdata = second_val;
        pix_d     = adv_pix;
        frame_d   = adv_frame;
        phase_d   = adv_phase;
        state_d   = ST_IDLE;
      end
      ST_DIV: begin
        num_d = quot_next;
        rem_d = div_rem;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIVN_W - 1)) begin
          if (is_feed_q) begin
            mean_we    = 1'b1;
            mean_wdata = quot_next[MEAN_W-1:0];
            m_d        = quot_next[MEAN_W-1:0];
            state_d    = ST_DIFF;
          end else if (op_q == OP_STDEV || op_q == OP_SSTDEV) begin
            num_d   = {quot_next[ACC_W-1:0], {FRAC_W{1'b0}}};
            srem_d  = '0;
            root_d  = '0;
            cnt_d   = '0;
            state_d = ST_SQRT;
          end else begin
            res_d   = quot_next[ACC_W-1:0];
            state_d = ST_OUT;
          end
        end
      end
      ST_SQRT: begin
        srem_d = sq_bit ? (sq_rem_sh - sq_trial) : sq_rem_sh;
        root_d = root_next;
        num_d  = {num_q[DIVN_W-3:0], 2'b00};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQ_STEPS - 1)) begin
          res_d   = ACC_W'(root_next);
          state_d = ST_OUT;
        end
      end
      ST_RD_RD: begin
        rem_d = '0;
        cnt_d = '0;
        case (op_q)
          OP_SUM, OP_MIN, OP_MAX: begin
            res_d   = acc_rd_q;
            state_d = ST_OUT;
          end
          OP_MEAN: begin
            num_d   = {acc_rd_q, {FRAC_W{1'b0}}};
            den_d   = nf;
            state_d = ST_DIV;
          end
          default: begin
            if (var_den == '0) begin
              de_d    = 1'b1;
              state_d = ST_OUT;
            end else begin
              num_d   = DIVN_W'(acc_rd_q);
              den_d   = var_den;
              state_d = ST_DIV;
            end
          end
        endcase
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {de_q, nr_q, res_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // register writes restart the run; the user must write them only while idle, the block does not enforce it
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_OPERATION: begin
          op_d    = op_e'(cfg_data_i[OPC_W-1:0]);
          phase_d = PASS_FIRST;
          pix_d   = '0;
          frame_d = '0;
        end
        CFG_FRAME_CNT: begin
          fcnt_d  = cfg_data_i[FCNT_W-1:0];
          phase_d = PASS_FIRST;
          pix_d   = '0;
          frame_d = '0;
        end
        CFG_PIXELS: begin
          ppf_d   = cfg_data_i[PPF_W-1:0];
          phase_d = PASS_FIRST;
          pix_d   = '0;
          frame_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_SUM;
      fcnt_q      <= FCNT_W'(1);
      ppf_q       <= PPF_W'(65536);
      phase_q     <= PASS_FIRST;
      pix_q       <= '0;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      fcnt_q      <= fcnt_d;
      ppf_q       <= ppf_d;
      phase_q     <= phase_d;
      pix_q       <= pix_d;
      frame_q     <= frame_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    is_feed_q  <= is_feed_d;
    x_q        <= x_d;
    acc_q      <= acc_d;
    m_q        <= m_d;
    dv_q       <= dv_d;
    sq_q       <= sq_d;
    num_q      <= num_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    cnt_q      <= cnt_d;
    srem_q     <= srem_d;
    root_q     <= root_d;
    res_q      <= res_d;
    nr_q       <= nr_d;
    de_q       <= de_d;
    out_data_q <= out_data_d;
  end

  // per-pixel stores; write address is the pixel in flight
  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[pix_q[AW-1:0]] <= acc_wdata;
    end
    if (rd_en) begin
      acc_rd_q <= acc_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mean_we) begin
      mean_mem[pix_q[AW-1:0]] <= mean_wdata;
    end
    if (rd_en) begin
      mean_rd_q <= mean_mem[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - RES_W){1'b0}}, out_data_q};

endmodule
